### src/aff_pkg.sv
// Shared types and constants for the affine warp bilinear sampler.
package aff_pkg;

    localparam int IMG_SIZE_DEF = 512;

    localparam int COORD_W = 9;
    localparam int PIX_W   = 8;
    localparam int COEF_W  = 18;
    localparam int OFF_W   = 29;
    localparam int FRAC_W  = 16;
    // Q.16 source position: |coef*coord| < 2^26, two of them plus offset stay below 2^30
    localparam int POS_W   = 31;
    localparam int PROD_W  = COEF_W + COORD_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = OFF_W;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_ROW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_COL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_ROW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_COL_ROW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_COL_COL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_COL   = 3'd5;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COEF_W-1:0] row_row;
        logic signed [COEF_W-1:0] row_col;
        logic signed [OFF_W-1:0]  off_row;
        logic signed [COEF_W-1:0] col_row;
        logic signed [COEF_W-1:0] col_col;
        logic signed [OFF_W-1:0]  off_col;
    } coef_t;

    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   pixel;
    } item_t;

    // Per-query side information that travels next to the fetched pixels
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               in_img;
        logic               has_r;
        logic               has_c;
        logic               tr0;
        logic               tc0;
        logic [FRAC_W-1:0]  fr;
        logic [FRAC_W-1:0]  fc;
    } fetch_t;

endpackage

### src/affine_rotate_bilinear_sampler.sv
// Affine warp sampler with bilinear interpolation over a banked 8-bit source image.
//
// The block accepts one transfer per clock while no result is held back and returns one
// result transfer per query from the output register; source pixel writes (tuser = 0) give no
// result. The pipeline is six register stages: two for the affine products and sums,
// one for the range check and the image read, two for the bilinear products and the
// last one, the output register, for the final sum and rounding. The source image is
// split into four banks by row and column parity, so the four neighbours of a position
// always fall into different banks and are read in the same cycle; each bank has one
// write and one read port and holds 4^clog2(ceil(IMG_SIZE/2)) pixels. Writes are applied at the
// same stage as query reads, so every query sees exactly the writes accepted before
// it. The store has no reset and no clearing pass: a pixel must be written before any
// query reads it. The whole pipeline holds while a result waits on m_tready.
module affine_rotate_bilinear_sampler #(
    parameter int IMG_SIZE = aff_pkg::IMG_SIZE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [aff_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [aff_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,  // row[8:0], col[17:9], pixel[25:18]
    input  logic [0:0]                        s_tuser,  // mode: 0 write pixel, 1 query
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata   // out_row[8:0], out_col[17:9],
                                                        // out_value[25:18]
);

    aff_pkg::coef_t  coef_reg;
    aff_pkg::item_t  in_item;
    aff_pkg::item_t  map_item;
    aff_pkg::fetch_t fetch;

    logic                                en;
    logic                                map_valid, fetch_valid;
    logic signed [aff_pkg::POS_W-1:0]    map_sr, map_sc;
    logic [3:0][aff_pkg::PIX_W-1:0]      fetch_q;
    logic [aff_pkg::COORD_W-1:0]         res_row, res_col;
    logic [aff_pkg::PIX_W-1:0]           res_value;

    // Advance every stage unless a finished result is held back
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign in_item.mode  = s_tuser[0];
    assign in_item.row   = s_tdata[8:0];
    assign in_item.col   = s_tdata[17:9];
    assign in_item.pixel = s_tdata[25:18];

    // Configuration registers: reset to the identity mapping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.row_row <= aff_pkg::COEF_W'(65536);
            coef_reg.row_col <= '0;
            coef_reg.off_row <= '0;
            coef_reg.col_row <= '0;
            coef_reg.col_col <= aff_pkg::COEF_W'(65536);
            coef_reg.off_col <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                aff_pkg::REG_COEF_ROW_ROW: coef_reg.row_row <= cfg_wdata[aff_pkg::COEF_W-1:0];
                aff_pkg::REG_COEF_ROW_COL: coef_reg.row_col <= cfg_wdata[aff_pkg::COEF_W-1:0];
                aff_pkg::REG_OFFSET_ROW:   coef_reg.off_row <= cfg_wdata[aff_pkg::OFF_W-1:0];
                aff_pkg::REG_COEF_COL_ROW: coef_reg.col_row <= cfg_wdata[aff_pkg::COEF_W-1:0];
                aff_pkg::REG_COEF_COL_COL: coef_reg.col_col <= cfg_wdata[aff_pkg::COEF_W-1:0];
                aff_pkg::REG_OFFSET_COL:   coef_reg.off_col <= cfg_wdata[aff_pkg::OFF_W-1:0];
                default: begin
                    // ignore writes beyond the register list
                end
            endcase
        end
    end

    // Stages 1-2: source position in Q.16
    aff_map u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_item   (in_item),
        .coef      (coef_reg),
        .out_valid (map_valid),
        .out_item  (map_item),
        .out_sr    (map_sr),
        .out_sc    (map_sc)
    );

    // Stage 3: range check, pixel write or 2x2 neighbourhood read
    aff_store #(
        .IMG_SIZE (IMG_SIZE)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (map_valid),
        .in_item   (map_item),
        .in_sr     (map_sr),
        .in_sc     (map_sc),
        .out_valid (fetch_valid),
        .out_fetch (fetch),
        .out_q     (fetch_q)
    );

    // Stages 4-6: weights, products, rounding into the output register
    aff_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fetch_valid),
        .in_fetch  (fetch),
        .in_q      (fetch_q),
        .out_valid (m_tvalid),
        .out_row   (res_row),
        .out_col   (res_col),
        .out_value (res_value)
    );

    assign m_tdata = {6'b0, res_value, res_col, res_row};

endmodule

### src/aff_map.sv
// Two-stage affine coordinate mapping to a Q.16 source position.
module aff_map (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  aff_pkg::item_t                in_item,
    input  aff_pkg::coef_t                coef,
    output logic                          out_valid,
    output aff_pkg::item_t                out_item,
    output logic signed [aff_pkg::POS_W-1:0] out_sr,
    output logic signed [aff_pkg::POS_W-1:0] out_sc
);

    logic signed [aff_pkg::COORD_W:0]  row_s;
    logic signed [aff_pkg::COORD_W:0]  col_s;

    logic                               v1_reg;
    aff_pkg::item_t                     item1_reg;
    logic signed [aff_pkg::PROD_W-1:0]  p_rr_reg, p_rc_reg, p_cr_reg, p_cc_reg;
    logic signed [aff_pkg::PROD_W-1:0]  p_rr_next, p_rc_next, p_cr_next, p_cc_next;

    logic                               v2_reg;
    aff_pkg::item_t                     item2_reg;
    logic signed [aff_pkg::POS_W-1:0]   sr_reg, sc_reg, sr_next, sc_next;

    assign row_s = $signed({1'b0, in_item.row});
    assign col_s = $signed({1'b0, in_item.col});

    always_comb begin
        p_rr_next = coef.row_row * row_s;
        p_rc_next = coef.row_col * col_s;
        p_cr_next = coef.col_row * row_s;
        p_cc_next = coef.col_col * col_s;
        sr_next = aff_pkg::POS_W'(p_rr_reg) + aff_pkg::POS_W'(p_rc_reg)
                + aff_pkg::POS_W'(coef.off_row);
        sc_next = aff_pkg::POS_W'(p_cr_reg) + aff_pkg::POS_W'(p_cc_reg)
                + aff_pkg::POS_W'(coef.off_col);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item1_reg <= in_item;
            p_rr_reg  <= p_rr_next;
            p_rc_reg  <= p_rc_next;
            p_cr_reg  <= p_cr_next;
            p_cc_reg  <= p_cc_next;
            item2_reg <= item1_reg;
            sr_reg    <= sr_next;
            sc_reg    <= sc_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item2_reg;
    assign out_sr    = sr_reg;
    assign out_sc    = sc_reg;

endmodule

### src/aff_store.sv
// Four-bank image store: source writes and the 2x2 neighbourhood fetch.
module aff_store #(
    parameter int IMG_SIZE = aff_pkg::IMG_SIZE_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  aff_pkg::item_t                      in_item,
    input  logic signed [aff_pkg::POS_W-1:0]    in_sr,
    input  logic signed [aff_pkg::POS_W-1:0]    in_sc,
    output logic                                out_valid,
    output aff_pkg::fetch_t                     out_fetch,
    output logic [3:0][aff_pkg::PIX_W-1:0]      out_q
);

    localparam int IDX_W  = (IMG_SIZE > 1) ? $clog2(IMG_SIZE) : 1;
    localparam int HALF   = (IMG_SIZE + 1) / 2;
    localparam int HW     = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int BANK_D = 2 ** (2 * HW);
    localparam int INT_W  = aff_pkg::POS_W - 1 - aff_pkg::FRAC_W;
    localparam logic [INT_W-1:0] LIMIT   = INT_W'(IMG_SIZE);
    localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(IMG_SIZE - 1);

    logic [IDX_W-1:0] tr, tc;
    logic [IDX_W:0]   wr_r, wr_c;
    logic             in_r, in_c, write_ok;
    aff_pkg::fetch_t  fetch_next;
    aff_pkg::fetch_t  fetch_reg;
    logic             valid_reg;

    always_comb begin
        tr   = in_sr[aff_pkg::FRAC_W +: IDX_W];
        tc   = in_sc[aff_pkg::FRAC_W +: IDX_W];
        in_r = !in_sr[aff_pkg::POS_W-1] && (in_sr[aff_pkg::POS_W-2:aff_pkg::FRAC_W] < LIMIT);
        in_c = !in_sc[aff_pkg::POS_W-1] && (in_sc[aff_pkg::POS_W-2:aff_pkg::FRAC_W] < LIMIT);
        wr_r = (IDX_W+1)'(in_item.row);
        wr_c = (IDX_W+1)'(in_item.col);
        // drop writes outside the image
        write_ok = in_valid && (in_item.mode == aff_pkg::MODE_WRITE)
                && (int'(in_item.row) < IMG_SIZE) && (int'(in_item.col) < IMG_SIZE);
        fetch_next.row    = in_item.row;
        fetch_next.col    = in_item.col;
        fetch_next.in_img = in_r && in_c;
        fetch_next.has_r  = (tr != LAST_IX);
        fetch_next.has_c  = (tc != LAST_IX);
        fetch_next.tr0    = tr[0];
        fetch_next.tc0    = tc[0];
        fetch_next.fr     = in_sr[aff_pkg::FRAC_W-1:0];
        fetch_next.fc     = in_sc[aff_pkg::FRAC_W-1:0];
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PR = ((b / 2) == 1);
        localparam logic PC = ((b % 2) == 1);

        logic [aff_pkg::PIX_W-1:0] mem [BANK_D];
        logic [aff_pkg::PIX_W-1:0] rd_reg;
        logic [IDX_W:0]            rp, cp;
        logic [2*HW-1:0]           raddr, waddr;
        logic                      we;

        always_comb begin
            // pick whichever of tr, tr+1 has this bank's row parity
            rp    = (tr[0] == PR) ? {1'b0, tr} : ({1'b0, tr} + 1'b1);
            cp    = (tc[0] == PC) ? {1'b0, tc} : ({1'b0, tc} + 1'b1);
            raddr = {rp[HW:1], cp[HW:1]};
            waddr = {wr_r[HW:1], wr_c[HW:1]};
            we    = write_ok && (wr_r[0] == PR) && (wr_c[0] == PC);
        end

        always_ff @(posedge aclk) begin
            if (en && we) begin
                mem[waddr] <= in_item.pixel;
            end
            if (en) begin
                rd_reg <= mem[raddr];
            end
        end

        assign out_q[b] = rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid && (in_item.mode == aff_pkg::MODE_QUERY);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fetch_reg <= fetch_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_fetch = fetch_reg;

endmodule

### src/aff_blend.sv
// Three-stage bilinear blend with half-up rounding; last stage is the output register.
module aff_blend (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  aff_pkg::fetch_t                   in_fetch,
    input  logic [3:0][aff_pkg::PIX_W-1:0]    in_q,
    output logic                              out_valid,
    output logic [aff_pkg::COORD_W-1:0]       out_row,
    output logic [aff_pkg::COORD_W-1:0]       out_col,
    output logic [aff_pkg::PIX_W-1:0]         out_value
);

    localparam int W_W   = aff_pkg::FRAC_W + 1;
    localparam int H_W   = aff_pkg::FRAC_W + aff_pkg::PIX_W;
    localparam int ACC_W = W_W + H_W;
    localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(64'd1 << (2 * aff_pkg::FRAC_W - 1));

    logic [aff_pkg::PIX_W-1:0] p00, p01, p10, p11;
    logic [W_W-1:0]            gc, fc, gr_next;
    logic [H_W-1:0]            h0_next, h1_next;

    logic                      v4_reg, v5_reg, v6_reg;
    logic [aff_pkg::COORD_W-1:0] row4_reg, col4_reg, row5_reg, col5_reg, row6_reg, col6_reg;
    logic                      in4_reg, in5_reg;
    logic [W_W-1:0]            gr_reg, fr_reg;
    logic [H_W-1:0]            h0_reg, h1_reg;
    logic [ACC_W-1:0]          m0_reg, m1_reg, m0_next, m1_next, acc;
    logic [aff_pkg::PIX_W-1:0] value_reg, value_next;

    always_comb begin
        // map banks back to neighbour positions; drop neighbours past the last row/column
        p00 = in_q[{in_fetch.tr0, in_fetch.tc0}];
        p01 = in_fetch.has_c ? in_q[{in_fetch.tr0, ~in_fetch.tc0}] : '0;
        p10 = in_fetch.has_r ? in_q[{~in_fetch.tr0, in_fetch.tc0}] : '0;
        p11 = (in_fetch.has_r && in_fetch.has_c) ? in_q[{~in_fetch.tr0, ~in_fetch.tc0}] : '0;
        fc      = {1'b0, in_fetch.fc};
        gc      = (W_W'(1) << aff_pkg::FRAC_W) - fc;
        gr_next = (W_W'(1) << aff_pkg::FRAC_W) - {1'b0, in_fetch.fr};
        h0_next = H_W'(gc * p00) + H_W'(fc * p01);
        h1_next = H_W'(gc * p10) + H_W'(fc * p11);
        m0_next = ACC_W'(gr_reg) * ACC_W'(h0_reg);
        m1_next = ACC_W'(fr_reg) * ACC_W'(h1_reg);
        acc     = m0_reg + m1_reg + HALF_LSB;
        value_next = in5_reg ? acc[2*aff_pkg::FRAC_W +: aff_pkg::PIX_W] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            row4_reg  <= in_fetch.row;
            col4_reg  <= in_fetch.col;
            in4_reg   <= in_fetch.in_img;
            gr_reg    <= gr_next;
            fr_reg    <= {1'b0, in_fetch.fr};
            h0_reg    <= h0_next;
            h1_reg    <= h1_next;
            row5_reg  <= row4_reg;
            col5_reg  <= col4_reg;
            in5_reg   <= in4_reg;
            m0_reg    <= m0_next;
            m1_reg    <= m1_next;
            row6_reg  <= row5_reg;
            col6_reg  <= col5_reg;
            value_reg <= value_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_row   = row6_reg;
    assign out_col   = col6_reg;
    assign out_value = value_reg;

endmodule
